// ===== sv/msp_pkg.sv =====
package msp_pkg;

  // Array bounds
  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;

  // Field widths
  localparam int ELEM_W    = 32;
  localparam int DIM_W     = 4;
  localparam int IDX_OUT_W = 3;

  // Index and count widths derived from the bounds
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 1'b0,
    CFG_NUM_COLS = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // store one incoming element
    logic scan_start;  // clear scan position and pending result
    logic rd_en;       // read stored element at scan position
    logic take;        // act on the compare result, advance scan
    logic finish;      // emit final result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;   // current load position is the final element
    logic saddle;      // element read back is a saddle point
    logic pend_valid;  // a saddle point is held back
    logic out_free;    // output register can take a result this cycle
    logic scan_last;   // scan is at the final element
  } dp_sts_t;

endpackage

// ===== sv/msp_elem_if.sv =====
interface msp_elem_if
  import msp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// ===== sv/msp_res_if.sv =====
interface msp_res_if
  import msp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [IDX_OUT_W-1:0]     row_index;
  logic [IDX_OUT_W-1:0]     col_index;
  logic signed [ELEM_W-1:0] point_value;
  logic                     none_found;
  logic                     last_result;

  modport source (output valid, output row_index, output col_index, output point_value,
                  output none_found, output last_result, input ready);
  modport sink   (input valid, input row_index, input col_index, input point_value,
                  input none_found, input last_result, output ready);
endinterface

// ===== sv/msp_ram.sv =====
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/msp_dp.sv =====
module msp_dp
  import msp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  input  logic signed [ELEM_W-1:0] elem_value_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [IDX_OUT_W-1:0]     out_row_o,
  output logic [IDX_OUT_W-1:0]     out_col_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic                     out_none_o,
  output logic                     out_last_o
);

  // Configuration and load position
  logic [DIM_W-1:0]     num_rows_q, num_cols_q;
  logic [ROW_W-1:0]     load_row_q;
  logic [COL_W-1:0]     load_col_q;
  logic [ROW_CNT_W-1:0] rows_c;
  logic [COL_CNT_W-1:0] cols_c;
  logic [ROW_W-1:0]     cur_r;
  logic [COL_W-1:0]     cur_c;
  logic                 stale;
  logic                 last_col, last_row;

  // Running extremes
  logic signed [ELEM_W-1:0] row_min_q [MAX_ROWS];
  logic signed [ELEM_W-1:0] row_max_q [MAX_ROWS];
  logic signed [ELEM_W-1:0] col_min_q [MAX_COLS];
  logic signed [ELEM_W-1:0] col_max_q [MAX_COLS];

  // Scan position, pending result, output register
  logic [ROW_W-1:0]         scan_r_q;
  logic [COL_W-1:0]         scan_c_q;
  logic                     pend_valid_q;
  logic [ROW_W-1:0]         pend_r_q;
  logic [COL_W-1:0]         pend_c_q;
  logic signed [ELEM_W-1:0] pend_v_q;
  logic                     out_valid_q;
  logic [IDX_OUT_W-1:0]     out_row_q, out_col_q;
  logic signed [ELEM_W-1:0] out_value_q;
  logic                     out_none_q, out_last_q;

  logic signed [ELEM_W-1:0] rd_data;
  logic [ELEM_W-1:0]        rd_raw;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic                     scan_last_c, scan_last_r;
  logic                     saddle;
  logic                     push_pend;

  // Dimensions: zero acts as one, above the bound acts as the bound
  always_comb begin
    if (num_rows_q == '0) begin
      rows_c = ROW_CNT_W'(1);
    end else if (int'(num_rows_q) > MAX_ROWS) begin
      rows_c = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_c = ROW_CNT_W'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      cols_c = COL_CNT_W'(1);
    end else if (int'(num_cols_q) > MAX_COLS) begin
      cols_c = COL_CNT_W'(MAX_COLS);
    end else begin
      cols_c = COL_CNT_W'(num_cols_q);
    end
  end

  // Effective load position, restarted if left outside the matrix
  assign stale    = (ROW_CNT_W'(load_row_q) >= rows_c) || (COL_CNT_W'(load_col_q) >= cols_c);
  assign cur_r    = stale ? '0 : load_row_q;
  assign cur_c    = stale ? '0 : load_col_q;
  assign last_col = (COL_CNT_W'(cur_c) + COL_CNT_W'(1)) == cols_c;
  assign last_row = (ROW_CNT_W'(cur_r) + ROW_CNT_W'(1)) == rows_c;

  // Configuration writes and load position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(MAX_ROWS);
      num_cols_q <= DIM_W'(MAX_COLS);
      load_row_q <= '0;
      load_col_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;
      endcase
      load_row_q <= '0;
      load_col_q <= '0;
    end else if (cmd_i.load) begin
      if (last_col) begin
        load_col_q <= '0;
        load_row_q <= last_row ? '0 : cur_r + ROW_W'(1);
      end else begin
        load_row_q <= cur_r;
        load_col_q <= cur_c + COL_W'(1);
      end
    end
  end

  // Row and column extremes; first element of a row or column seeds them
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (cur_c == '0 || elem_value_i < row_min_q[cur_r]) begin
        row_min_q[cur_r] <= elem_value_i;
      end
      if (cur_c == '0 || elem_value_i > row_max_q[cur_r]) begin
        row_max_q[cur_r] <= elem_value_i;
      end
      if (cur_r == '0 || elem_value_i < col_min_q[cur_c]) begin
        col_min_q[cur_c] <= elem_value_i;
      end
      if (cur_r == '0 || elem_value_i > col_max_q[cur_c]) begin
        col_max_q[cur_c] <= elem_value_i;
      end
    end
  end

  // Element store
  assign waddr = ADDR_W'(int'(cur_r) * MAX_COLS + int'(cur_c));
  assign raddr = ADDR_W'(int'(scan_r_q) * MAX_COLS + int'(scan_c_q));

  msp_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  assign rd_data = rd_raw;

  // Saddle test on the element read back
  assign saddle = ((rd_data == row_min_q[scan_r_q]) && (rd_data == col_max_q[scan_c_q])) ||
                  ((rd_data == row_max_q[scan_r_q]) && (rd_data == col_min_q[scan_c_q]));
  assign scan_last_c = (COL_CNT_W'(scan_c_q) + COL_CNT_W'(1)) == cols_c;
  assign scan_last_r = (ROW_CNT_W'(scan_r_q) + ROW_CNT_W'(1)) == rows_c;
  assign push_pend   = cmd_i.take && saddle && pend_valid_q;

  // Scan position, pending flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_r_q     <= '0;
      scan_c_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_r_q     <= '0;
        scan_c_q     <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.take) begin
        if (scan_last_c) begin
          scan_c_q <= '0;
          scan_r_q <= scan_r_q + ROW_W'(1);
        end else begin
          scan_c_q <= scan_c_q + COL_W'(1);
        end
        if (saddle) begin
          pend_valid_q <= 1'b1;
        end
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      if (push_pend || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && saddle) begin
      pend_r_q <= scan_r_q;
      pend_c_q <= scan_c_q;
      pend_v_q <= rd_data;
    end
    if (push_pend || (cmd_i.finish && pend_valid_q)) begin
      out_row_q   <= IDX_OUT_W'(pend_r_q);
      out_col_q   <= IDX_OUT_W'(pend_c_q);
      out_value_q <= pend_v_q;
      out_none_q  <= 1'b0;
      out_last_q  <= cmd_i.finish;
    end else if (cmd_i.finish) begin
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_none_q  <= 1'b1;
      out_last_q  <= 1'b1;
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.load_last  = last_col && last_row;
    sts_o.saddle     = saddle;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.scan_last  = scan_last_c && scan_last_r;
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_none_o  = out_none_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== sv/msp_ctrl.sv =====
module msp_ctrl
  import msp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.load_last) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        // a new hit pushes the held one out, so the output must be free
        if (!(sts_i.saddle && sts_i.pend_valid && !sts_i.out_free)) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.scan_last ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

// ===== sv/matrix_saddle_point_finder.sv =====
// Matrix saddle point finder.
// elem_i takes the matrix elements in row-major order, one signed 32-bit
// value per transfer, rows x columns as set by the num_rows / num_cols
// registers (index 0 and 1 of the write port; 0 acts as 1, values above the
// bound act as the bound). Any register write restarts loading at row 0.
// Elements load at one per cycle. The transfer of the final element starts a
// scan of the element store: each stored element gets one RAM read, then one
// compare against the row and column extremes. Each hit is held back until
// the next hit or the end of the scan shows whether it is the last one, so the
// first result shows when the second saddle point is checked, or at the end.
// res_o gives each saddle point (row, column, value) in row-major order, the
// final one with last_result set, or one result with none_found set.
// elem_i is not ready during the scan. A stall on res_o holds the scan once
// a second hit has to go out; the output register holds its result stable.
// Reset clears the position and output valid and sets both dimensions to 8.
module matrix_saddle_point_finder
  import msp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  msp_elem_if.sink             elem_i,
  msp_res_if.source            res_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (elem_i.valid),
    .in_ready_o (elem_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .elem_value_i (elem_i.element_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_row_o    (res_o.row_index),
    .out_col_o    (res_o.col_index),
    .out_value_o  (res_o.point_value),
    .out_none_o   (res_o.none_found),
    .out_last_o   (res_o.last_result)
  );

endmodule
